// ===== rtl/assert_macros.svh =====
// Assertion macros for the quadrature emulator RTL.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define ATQE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("atqe assertion failed");
// Condition in one cycle implies a consequence in the next.
`define ATQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atqe assertion failed");
`else
`define ATQE_ASSERT(lbl, clk, rst_n, prop)
`define ATQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/atqe_pkg.sv =====
// Shared types, constants and helpers of the quadrature emulator.
// No dependencies.
package atqe_pkg;

    localparam int POS_W    = 12;
    localparam int STEP_W   = 8;
    localparam int SAMPLE_W = 10;

    localparam logic [STEP_W-1:0] STEP_RESET  = 8'd4;
    localparam logic [1:0]        LINES_RESET = 2'b11;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_CAL    = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]              phase;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] offset;
        logic [1:0]              lines;   // bit 0 line A, bit 1 line B
    } t_axis_state;

    // Gray order forward: 00, 01, 11, 10.
    function automatic logic [1:0] fwd_phase(input logic [1:0] p);
        case (p)
            2'b00:   return 2'b01;
            2'b01:   return 2'b11;
            2'b11:   return 2'b10;
            default: return 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] back_phase(input logic [1:0] p);
        case (p)
            2'b00:   return 2'b10;
            2'b10:   return 2'b11;
            2'b11:   return 2'b01;
            default: return 2'b00;
        endcase
    endfunction

    // Clamp a 13-bit signed value into the 12-bit signed range.
    function automatic logic signed [POS_W-1:0] sat12(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1]) begin
            r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/atqe_axis.sv =====
// One axis of the quadrature emulator: phase, tracked position, latched
// difference and line levels. Depends on atqe_pkg.
module atqe_axis (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [1:0]                    i_cmd,
    input  logic                          i_sel,
    input  logic [atqe_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [atqe_pkg::STEP_W-1:0]   i_step,
    output atqe_pkg::t_axis_state         o_state
);
    import atqe_pkg::*;

    t_axis_state r_state;
    t_axis_state n_state;

    logic signed [POS_W:0]   sample_ext;
    logic signed [POS_W:0]   pos_ext;
    logic signed [POS_W:0]   off_ext;
    logic signed [POS_W:0]   step_ext;
    logic signed [POS_W:0]   diff;
    logic signed [POS_W:0]   pos_up;
    logic signed [POS_W:0]   pos_dn;
    logic [1:0]              ph_fwd;
    logic [1:0]              ph_back;
    logic                    go_fwd;
    logic                    go_back;

    always_comb begin
        sample_ext = $signed({{(POS_W+1-SAMPLE_W){1'b0}}, i_sample});
        pos_ext    = $signed({r_state.position[POS_W-1], r_state.position});
        off_ext    = $signed({r_state.offset[POS_W-1], r_state.offset});
        step_ext   = $signed({{(POS_W+1-STEP_W){1'b0}}, i_step});
        diff       = sample_ext - pos_ext;
        pos_up     = pos_ext + step_ext;
        pos_dn     = pos_ext - step_ext;
        ph_fwd     = fwd_phase(r_state.phase);
        ph_back    = back_phase(r_state.phase);
        go_fwd     = off_ext > step_ext;
        go_back    = off_ext < -step_ext;

        n_state = r_state;
        case (i_cmd)
            CMD_TICK: begin
                if (go_fwd) begin
                    n_state.phase = ph_fwd;
                    n_state.lines = ph_fwd;
                    if (ph_fwd == 2'b00) n_state.position = sat12(pos_up);
                end else if (go_back) begin
                    n_state.phase = ph_back;
                    n_state.lines = ph_back;
                    if (ph_back == 2'b00) n_state.position = sat12(pos_dn);
                end
            end
            CMD_SAMPLE: begin
                if (i_sel) n_state.offset = sat12(diff);
            end
            CMD_CAL: begin
                if (i_sel) n_state.position = sample_ext[POS_W-1:0];
            end
            default: begin
                // unused command: hold
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= '0;
            r_state.position <= '0;
            r_state.offset   <= '0;
            r_state.lines    <= LINES_RESET;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ===== rtl/analog_to_quadrature_emulator_core.sv =====
// Top level of the two-axis quadrature encoder emulator.
// Depends on atqe_pkg, atqe_axis and assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one command per transfer:
//   tick (advance each axis whose latched difference is outside the dead
//   band), sample (latch sample minus tracked position for one axis) or
//   calibrate (load the tracked position of one axis).
//   Output channel (o_valid / i_ready) carries one result per command: the
//   four encoder lines and both tracked positions after that command.
//   A command goes through the input register, then the axis state,
//   which doubles as the result register. One command per cycle while the
//   receiver is ready; the state update is a 13-bit subtract, a compare
//   and a two-bit phase step, done in the cycle the input register moves.
//   When the receiver stalls, the result and axis state hold, the input
//   register takes one more command, then o_ready drops until the result
//   is taken.
//   Reset: step size 4, phases 00, positions and differences 0, all four
//   lines high until an axis first moves. Write the step size through
//   i_step_wr_en / i_step_wr_data only while the block is idle.
`include "assert_macros.svh"
module analog_to_quadrature_emulator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_step_wr_en,
    input  logic [atqe_pkg::STEP_W-1:0]   i_step_wr_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic                          i_axis_sel,
    input  logic [atqe_pkg::SAMPLE_W-1:0] i_sample_value,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_x_chan_a,
    output logic                          o_x_chan_b,
    output logic                          o_y_chan_a,
    output logic                          o_y_chan_b,
    output logic signed [atqe_pkg::POS_W-1:0] o_x_tracked,
    output logic signed [atqe_pkg::POS_W-1:0] o_y_tracked
);
    import atqe_pkg::*;

    logic [STEP_W-1:0]   r_step;
    logic                r_in_valid;
    logic [1:0]          r_cmd;
    logic                r_axis_sel;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;

    logic                adv;
    logic                in_xfer;
    t_axis_state         x_state;
    t_axis_state         y_state;

    // Advance the input register into the axis state when the result
    // slot is free or being drained this cycle.
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;
    assign in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_step_wr_en) begin
            r_step <= i_step_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd      <= i_cmd;
            r_axis_sel <= i_axis_sel;
            r_sample   <= i_sample_value;
        end
    end

    atqe_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_cmd    (r_cmd),
        .i_sel    (!r_axis_sel),
        .i_sample (r_sample),
        .i_step   (r_step),
        .o_state  (x_state)
    );

    atqe_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_cmd    (r_cmd),
        .i_sel    (r_axis_sel),
        .i_sample (r_sample),
        .i_step   (r_step),
        .o_state  (y_state)
    );

    // Axis state only changes on advance, so it serves as the result register.
    assign o_valid     = r_out_valid;
    assign o_x_chan_a  = x_state.lines[0];
    assign o_x_chan_b  = x_state.lines[1];
    assign o_y_chan_a  = y_state.lines[0];
    assign o_y_chan_b  = y_state.lines[1];
    assign o_x_tracked = x_state.position;
    assign o_y_tracked = y_state.position;

    // Tracked position holds whenever no command advances.
    `ATQE_ASSERT_NEXT(a_x_pos_hold, i_clk, i_rst_n, !adv, $stable(o_x_tracked))
    // Y encoder lines change by at most one bit per cycle (Gray stepping).
    `ATQE_ASSERT(a_y_gray, i_clk, i_rst_n, 1'b1 |=> ($countones({o_y_chan_b, o_y_chan_a} ^ $past({o_y_chan_b, o_y_chan_a})) <= 1))
    // Calibrate of x loads the sample as the tracked position.
    `ATQE_ASSERT_NEXT(a_x_cal, i_clk, i_rst_n, adv && (r_cmd == CMD_CAL) && !r_axis_sel, o_x_tracked == $signed({2'b00, $past(r_sample)}))

endmodule
